// File: rtl/slcd_pkg.sv
// constants and register codes shared by the sync/length/checksum deframer
// no dependencies

package slcd_pkg;

    // largest payload a frame may carry
    localparam int MAX_PAYLOAD = 255;
    // sync a, sync b, command, length, checksum
    localparam int FRAME_OVERHEAD = 5;
    localparam int WIN_DEPTH = MAX_PAYLOAD + FRAME_OVERHEAD;
    // window ram is a power of two deep and addressed as a ring
    localparam int WIN_AW = $clog2(WIN_DEPTH);
    localparam int CNT_W = $clog2(WIN_DEPTH + 1);

    localparam int BYTE_W = 8;
    // held payload ram: one bank bit and a byte index
    localparam int HELD_AW = BYTE_W + 1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;

    // apb register map, 4 bytes a register
    localparam int APB_AW = 3;
    localparam int REG_IW = APB_AW - 2;
    localparam logic [REG_IW-1:0] REG_SYNC_FIRST = 1'b0;
    localparam logic [REG_IW-1:0] REG_SYNC_SECOND = 1'b1;

    // input word kinds
    localparam logic KIND_RX = 1'b0;
    localparam logic KIND_READ = 1'b1;

endpackage

// File: rtl/slcd_ram.sv
// generic single write, single read ram with registered read data
// no dependencies

module slcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sync_len_checksum_deframer.sv
// frame parser top level: window ring buffer, scan sequencer, held payload banks
// depends on slcd_pkg and slcd_ram

// Received bytes are appended to a ring-buffer window and scanned for frames
// of sync A, sync B, command, length, payload, checksum; one result word comes
// back for every input word. All window accesses go through the single read
// port of the window ram, so the sequencer looks at one buffered byte a cycle;
// the byte that completes a frame adds a walk over its payload for the checksum
// sum, and a checksum failure rescans the rest of the window from its next byte,
// summing again every candidate frame that starts there. Input is accepted
// only between words; a finished result waits in the output register without
// blocking the next input word. The payload of a good frame is collected into
// the spare bank of the held payload ram while it is summed, and the banks swap
// when the checksum matches, so no copy pass follows. No clearing pass is run
// after reset.

module sync_len_checksum_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic [slcd_pkg::BYTE_W-1:0]         i_rx_byte,
    input  logic [slcd_pkg::BYTE_W-1:0]         i_read_index,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_frame_found,
    output logic [slcd_pkg::BYTE_W-1:0]         o_frame_cmd,
    output logic [slcd_pkg::BYTE_W-1:0]         o_frame_len,
    output logic                                o_checksum_failed,
    output logic [slcd_pkg::BYTE_W-1:0]         o_payload_byte,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [slcd_pkg::APB_AW-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOP,
        S_B0,
        S_B1,
        S_B3,
        S_CMD,
        S_SUM,
        S_RDW,
        S_DONE
    } t_state;

    localparam int BW = slcd_pkg::BYTE_W;
    localparam int AW = slcd_pkg::WIN_AW;
    localparam int CW = slcd_pkg::CNT_W;

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [BW-1:0] r_len, n_len;
    logic [BW-1:0] r_sum, n_sum;
    logic [BW-1:0] r_idx, n_idx;
    logic [BW-1:0] r_cmd, n_cmd;
    logic          r_found, n_found;
    logic          r_failed, n_failed;
    logic [BW-1:0] r_ridx, n_ridx;
    logic          r_bank, n_bank;
    logic [BW-1:0] r_held_cmd, n_held_cmd;
    logic [BW-1:0] r_held_len, n_held_len;
    logic [BW-1:0] r_sync_first, r_sync_second;

    logic          r_out_valid, n_out_valid;
    logic          r_o_found, n_o_found;
    logic          r_o_failed, n_o_failed;
    logic [BW-1:0] r_o_cmd, n_o_cmd;
    logic [BW-1:0] r_o_len, n_o_len;
    logic [BW-1:0] r_o_pbyte, n_o_pbyte;
    logic [BW-1:0] r_pbyte;

    logic                         in_acc;
    logic                         out_acc;
    logic                         cfg_wr;
    logic [slcd_pkg::REG_IW-1:0]  cfg_idx;
    logic                         do_drop;
    logic                         pbyte_sel;
    logic [AW-1:0]                rd_off;
    logic                         win_we;
    logic [AW-1:0]                win_waddr;
    logic [AW-1:0]                win_raddr;
    logic [BW-1:0]                win_rdata;
    logic                         held_we;
    logic [slcd_pkg::HELD_AW-1:0] held_waddr;
    logic [slcd_pkg::HELD_AW-1:0] held_raddr;
    logic [BW-1:0]                held_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_out_valid && i_out_ready;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[slcd_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            slcd_pkg::REG_SYNC_FIRST:  prdata = {{(32-BW){1'b0}}, r_sync_first};
            slcd_pkg::REG_SYNC_SECOND: prdata = {{(32-BW){1'b0}}, r_sync_second};
            default:                   prdata = '0;
        endcase
    end

    slcd_ram #(
        .WIDTH (BW),
        .DEPTH (2 ** AW)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    slcd_ram #(
        .WIDTH (BW),
        .DEPTH (2 ** slcd_pkg::HELD_AW)
    ) u_held_ram (
        .i_clk   (i_clk),
        .i_we    (held_we),
        .i_waddr (held_waddr),
        .i_wdata (win_rdata),
        .i_raddr (held_raddr),
        .o_rdata (held_rdata)
    );

    // new byte lands at the tail; a full window is impossible but drops its front
    assign win_we     = in_acc && (i_kind == slcd_pkg::KIND_RX);
    assign win_waddr  = r_head + AW'(r_count);
    assign held_raddr = {r_bank, i_read_index};
    assign held_we    = (r_state == S_SUM) && (r_idx != r_len);
    assign held_waddr = {~r_bank, r_idx};

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_len       = r_len;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_found     = r_found;
        n_failed    = r_failed;
        n_ridx      = r_ridx;
        n_bank      = r_bank;
        n_held_cmd  = r_held_cmd;
        n_held_len  = r_held_len;
        n_out_valid = r_out_valid && !out_acc;
        n_o_found   = r_o_found;
        n_o_failed  = r_o_failed;
        n_o_cmd     = r_o_cmd;
        n_o_len     = r_o_len;
        n_o_pbyte   = r_o_pbyte;
        do_drop     = 1'b0;
        rd_off      = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_found  = 1'b0;
                    n_failed = 1'b0;
                    n_ridx   = i_read_index;
                    if (i_kind == slcd_pkg::KIND_READ) begin
                        n_state = S_RDW;
                    end else begin
                        if (r_count == CW'(slcd_pkg::WIN_DEPTH)) begin
                            n_head = r_head + AW'(1);
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                        n_state = S_LOOP;
                    end
                end
            end
            S_LOOP: begin
                n_state = S_B0;
            end
            S_B0: begin
                if (win_rdata != r_sync_first) begin
                    do_drop = 1'b1;
                end else if (r_count < CW'(2)) begin
                    n_state = S_DONE;
                end else begin
                    rd_off  = AW'(1);
                    n_state = S_B1;
                end
            end
            S_B1: begin
                if (win_rdata != r_sync_second) begin
                    do_drop = 1'b1;
                end else if (r_count < CW'(4)) begin
                    n_state = S_DONE;
                end else begin
                    rd_off  = AW'(3);
                    n_state = S_B3;
                end
            end
            S_B3: begin
                n_len = win_rdata;
                if (CW'(win_rdata) > CW'(slcd_pkg::MAX_PAYLOAD)) begin
                    do_drop = 1'b1;
                end else if (r_count < CW'(win_rdata) + CW'(slcd_pkg::FRAME_OVERHEAD)) begin
                    n_state = S_DONE;
                end else begin
                    rd_off  = AW'(2);
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                n_cmd   = win_rdata;
                n_sum   = win_rdata + r_len;
                n_idx   = '0;
                rd_off  = AW'(4);
                n_state = S_SUM;
            end
            S_SUM: begin
                // byte at offset 4 + idx: payload until idx reaches len, then checksum
                if (r_idx == r_len) begin
                    if (win_rdata == BW'(8'd0 - r_sum)) begin
                        n_held_cmd = r_cmd;
                        n_held_len = r_len;
                        n_bank     = ~r_bank;
                        n_count    = '0;
                        n_found    = 1'b1;
                        n_state    = S_DONE;
                    end else begin
                        n_failed = 1'b1;
                        do_drop  = 1'b1;
                    end
                end else begin
                    n_sum  = r_sum + win_rdata;
                    n_idx  = r_idx + BW'(1);
                    rd_off = AW'(r_idx) + AW'(5);
                end
            end
            S_RDW: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_found;
                    n_o_failed  = r_failed;
                    n_o_cmd     = r_held_cmd;
                    n_o_len     = r_held_len;
                    n_o_pbyte   = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_drop) begin
            n_head  = r_head + AW'(1);
            n_count = r_count - CW'(1);
            rd_off  = '0;
            if (r_count == CW'(1)) begin
                n_state = S_DONE;
            end else begin
                n_state = S_B0;
            end
        end

        // read-back data is registered out of the ram in the cycle after acceptance
        if (r_state == S_RDW && r_ridx < r_held_len) begin
            pbyte_sel = 1'b1;
        end else begin
            pbyte_sel = 1'b0;
        end
    end

    assign win_raddr = n_head + rd_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_count       <= '0;
            r_len         <= '0;
            r_sum         <= '0;
            r_idx         <= '0;
            r_cmd         <= '0;
            r_found       <= 1'b0;
            r_failed      <= 1'b0;
            r_ridx        <= '0;
            r_bank        <= 1'b0;
            r_held_cmd    <= '0;
            r_held_len    <= '0;
            r_sync_first  <= slcd_pkg::SYNC_FIRST_RESET;
            r_sync_second <= slcd_pkg::SYNC_SECOND_RESET;
            r_out_valid   <= 1'b0;
            r_o_found     <= 1'b0;
            r_o_failed    <= 1'b0;
            r_o_cmd       <= '0;
            r_o_len       <= '0;
            r_o_pbyte     <= '0;
            r_pbyte       <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_len       <= n_len;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            r_cmd       <= n_cmd;
            r_found     <= n_found;
            r_failed    <= n_failed;
            r_ridx      <= n_ridx;
            r_bank      <= n_bank;
            r_held_cmd  <= n_held_cmd;
            r_held_len  <= n_held_len;
            r_out_valid <= n_out_valid;
            r_o_found   <= n_o_found;
            r_o_failed  <= n_o_failed;
            r_o_cmd     <= n_o_cmd;
            r_o_len     <= n_o_len;
            if (r_state == S_RDW) begin
                r_pbyte <= pbyte_sel ? held_rdata : '0;
            end else if (r_state == S_IDLE) begin
                r_pbyte <= '0;
            end
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_o_pbyte <= r_pbyte;
            end else begin
                r_o_pbyte <= n_o_pbyte;
            end
            if (cfg_wr && cfg_idx == slcd_pkg::REG_SYNC_FIRST) begin
                r_sync_first <= pwdata[BW-1:0];
            end
            if (cfg_wr && cfg_idx == slcd_pkg::REG_SYNC_SECOND) begin
                r_sync_second <= pwdata[BW-1:0];
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_found     = r_o_found;
    assign o_checksum_failed = r_o_failed;
    assign o_frame_cmd       = r_o_cmd;
    assign o_frame_len       = r_o_len;
    assign o_payload_byte    = r_o_pbyte;

    // window never holds more than one maximal frame
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(slcd_pkg::WIN_DEPTH))
        else $error("window count beyond depth");

    // an accepted word keeps the input closed for at least the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while busy");

    // checksum walk never passes the checksum byte
    a_sum_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_idx <= r_len))
        else $error("sum index past frame length");

    // a word that completed a frame was a received byte, so no read-back data
    a_found_no_pbyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_found) |-> (o_payload_byte == '0))
        else $error("payload byte on a frame result");

endmodule
